### rtl/core/edf_task_scheduler_core_assert.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by files that assert.
`ifndef EDF_TASK_SCHEDULER_CORE_ASSERT_SVH
`define EDF_TASK_SCHEDULER_CORE_ASSERT_SVH
// Assert an implication, checked while out of reset.
`define EDF_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("edf: %s failed", "label");
// Assert an implication whose consequent is checked in the next cycle.
`define EDF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("edf: %s failed", "label");
`endif

### rtl/core/edf_pkg.sv
// Package for the EDF scheduler: widths, event and status codes, slot states,
// controller command and status structs. No dependencies.
`default_nettype none
package edf_pkg;
	localparam int unsigned SLOTS_DEF = 16;
	localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

	localparam logic [2:0] FN_ALLOC = 3'd0;
	localparam logic [2:0] FN_ENQ = 3'd1;
	localparam logic [2:0] FN_BLOCK = 3'd2;
	localparam logic [2:0] FN_UNBLOCK = 3'd3;
	localparam logic [2:0] FN_SCHED = 3'd4;
	localparam logic [2:0] FN_YIELD = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_NOTRUN = 2'd2;

	localparam logic [1:0] SS_FREE = 2'd0;
	localparam logic [1:0] SS_IDLE = 2'd1;
	localparam logic [1:0] SS_READY = 2'd2;
	localparam logic [1:0] SS_WAIT = 2'd3;

	typedef struct packed {
		logic load;      // latch the event
		logic scan_clr;  // start a scan
		logic scan_step; // compare one slot
		logic release_w; // release head of wait queue
		logic finish;    // apply the event and build the result
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic wait_due;  // wait head exists and deadline <= now
	} sts_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? ALL_ONES : s[63:0];
	endfunction
endpackage
`default_nettype wire

### rtl/core/edf_if.sv
// Valid/ready channel interface carrying one payload of type T.
// No dependencies.
`default_nettype none
interface edf_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/edf_ctrl.sv
// Controller FSM for the EDF scheduler: sequences scan, release and finish.
// Depends on edf_pkg.
`default_nettype none
module edf_ctrl import edf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire logic is_sched,
	input wire sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_REL = 5'b00100,
		S_FIN = 5'b01000,
		S_OUT = 5'b10000
	} state_t;
	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = S_REL;
			end
			S_REL: begin
				// on a schedule event, release one due waiting slot per pass, then rescan
				if (is_sched && sts.wait_due) begin
					cmd.release_w = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	`include "edf_task_scheduler_core_assert.svh"
	`EDF_ASSERT_IMP(a_one_hot, clk, arst_n, 1'b1, $onehot(state_q))
	`EDF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`EDF_ASSERT_IMP(a_no_overlap, clk, arst_n, in_ready, !out_valid)
endmodule
`default_nettype wire

### rtl/core/edf_dp.sv
// Datapath for the EDF scheduler: slot table, sequential queue-head scans,
// release and event application. Depends on edf_pkg.
`default_nettype none
module edf_dp import edf_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	output sts_t sts,
	output logic is_sched,
	input wire logic [2:0] in_func,
	input wire logic [3:0] in_slot,
	input wire logic [63:0] in_now,
	input wire logic [31:0] in_period,
	input wire logic [63:0] in_first,
	input wire logic [31:0] in_budget,
	output logic [3:0] run_slot,
	output logic run_valid,
	output logic [3:0] alloc_slot,
	output logic [1:0] status,
	output logic end_timer_set,
	output logic end_timer_cancel,
	output logic [63:0] end_time,
	output logic release_valid,
	output logic [63:0] release_time,
	output logic resched_request
);
	localparam int unsigned IW = $clog2(SLOTS);
	localparam int unsigned CW = $clog2(SLOTS + 1);

	logic [1:0] st_q [SLOTS];
	logic [63:0] dl_q [SLOTS];
	logic [31:0] rem_q [SLOTS];
	logic [63:0] start_q [SLOTS];
	logic [31:0] per_q [SLOTS];
	logic [31:0] bud_q [SLOTS];
	logic [31:0] ord_q [SLOTS];
	logic [31:0] octr_q;
	logic [IW-1:0] run_q;
	logic runv_q;

	logic [2:0] func_q;
	logic [3:0] slot_q;
	logic [63:0] now_q, first_q;
	logic [31:0] period_q, budget_q;

	// scan registers: heads of ready/wait queue, first free slot
	logic [CW-1:0] idx_q;
	logic [IW-1:0] rh_q, wh_q, fr_q;
	logic rhv_q, whv_q, frv_q;

	logic [IW-1:0] idx;
	assign idx = idx_q[IW-1:0];
	assign sts = '{scan_done: (idx_q == CW'(SLOTS - 1)),
		wait_due: (whv_q && (dl_q[wh_q] <= now_q))};
	assign is_sched = (func_q == FN_SCHED);

	logic in_range;
	logic [IW-1:0] sl;
	assign in_range = ({28'd0, slot_q} < 32'(SLOTS));
	assign sl = IW'(slot_q);

	function automatic logic better(input logic [63:0] di, input logic [31:0] oi,
			input logic [63:0] db, input logic [31:0] ob, input logic [31:0] oc);
		logic [31:0] ai, ab;
		ai = oc - oi;
		ab = oc - ob;
		return (di < db) || (di == db && ai > ab);
	endfunction

	logic [63:0] used_run, used_sl;
	logic [31:0] new_rem;
	logic keep;
	assign used_run = now_q - start_q[run_q];
	assign used_sl = now_q - start_q[sl];
	assign new_rem = (used_sl >= {32'd0, rem_q[sl]}) ? 32'd0 : (rem_q[sl] - used_sl[31:0]);
	assign keep = runv_q && ({32'd0, rem_q[run_q]} > used_run) && (dl_q[run_q] < dl_q[rh_q]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			slot_q <= in_slot;
			now_q <= in_now;
			first_q <= in_first;
			period_q <= in_period;
			budget_q <= in_budget;
		end
		if (cmd.scan_clr) begin
			idx_q <= '0;
			rhv_q <= 1'b0;
			whv_q <= 1'b0;
			frv_q <= 1'b0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + CW'(1);
			if (st_q[idx] == SS_READY && (!rhv_q ||
					better(dl_q[idx], ord_q[idx], dl_q[rh_q], ord_q[rh_q], octr_q))) begin
				rh_q <= idx;
				rhv_q <= 1'b1;
			end
			if (st_q[idx] == SS_WAIT && (!whv_q ||
					better(dl_q[idx], ord_q[idx], dl_q[wh_q], ord_q[wh_q], octr_q))) begin
				wh_q <= idx;
				whv_q <= 1'b1;
			end
			if (st_q[idx] == SS_FREE && !frv_q) begin
				fr_q <= idx;
				frv_q <= 1'b1;
			end
		end
		if (cmd.release_w) begin
			dl_q[wh_q] <= sat_add(dl_q[wh_q], {32'd0, per_q[wh_q]});
			rem_q[wh_q] <= bud_q[wh_q];
			ord_q[wh_q] <= octr_q;
		end
		if (cmd.finish) begin
			alloc_slot <= '0;
			status <= ST_OK;
			end_timer_set <= 1'b0;
			end_timer_cancel <= 1'b0;
			end_time <= '0;
			release_valid <= 1'b0;
			release_time <= '0;
			resched_request <= 1'b0;
			case (func_q)
				FN_ALLOC: begin
					if (!frv_q) status <= ST_NOFREE;
					else begin
						per_q[fr_q] <= period_q;
						bud_q[fr_q] <= budget_q;
						rem_q[fr_q] <= budget_q;
						dl_q[fr_q] <= (period_q != 0) ? sat_add(first_q, {32'd0, period_q})
							: ALL_ONES;
						alloc_slot <= 4'(fr_q);
					end
				end
				FN_ENQ: begin
					if (in_range && st_q[sl] == SS_IDLE) ord_q[sl] <= octr_q;
				end
				FN_BLOCK: begin
					if (in_range && runv_q && run_q == sl) begin
						rem_q[sl] <= new_rem;
						ord_q[sl] <= octr_q;
						end_timer_cancel <= 1'b1;
						resched_request <= 1'b1;
					end else status <= ST_NOTRUN;
				end
				FN_UNBLOCK: begin
					if (in_range && st_q[sl] == SS_IDLE && !(runv_q && run_q == sl)) begin
						ord_q[sl] <= octr_q;
						resched_request <= 1'b1;
					end
				end
				FN_SCHED: begin
					if (whv_q) begin
						release_valid <= 1'b1;
						release_time <= dl_q[wh_q];
					end
					if (rhv_q && !keep) begin
						start_q[rh_q] <= now_q;
						end_timer_cancel <= 1'b1;
						end_timer_set <= 1'b1;
						end_time <= sat_add(now_q, {32'd0, rem_q[rh_q]});
					end
				end
				FN_YIELD: begin
					end_timer_cancel <= 1'b1;
					resched_request <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// control state: slot status, order counter, running task
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) st_q[i] <= SS_FREE;
			octr_q <= '0;
			run_q <= '0;
			runv_q <= 1'b0;
		end else begin
			if (cmd.release_w) begin
				st_q[wh_q] <= SS_READY;
				octr_q <= octr_q + 32'd1;
			end
			if (cmd.finish) begin
				case (func_q)
					FN_ALLOC: if (frv_q) st_q[fr_q] <= SS_IDLE;
					FN_ENQ: begin
						if (in_range && st_q[sl] == SS_IDLE) begin
							st_q[sl] <= SS_READY;
							octr_q <= octr_q + 32'd1;
						end
					end
					FN_BLOCK: begin
						if (in_range && runv_q && run_q == sl) begin
							st_q[sl] <= (new_rem == 0) ? SS_WAIT : SS_READY;
							octr_q <= octr_q + 32'd1;
							runv_q <= 1'b0;
							run_q <= '0;
						end
					end
					FN_UNBLOCK: begin
						if (in_range && st_q[sl] == SS_IDLE && !(runv_q && run_q == sl)) begin
							st_q[sl] <= (rem_q[sl] == 0) ? SS_WAIT : SS_READY;
							octr_q <= octr_q + 32'd1;
						end
					end
					FN_SCHED: begin
						if (rhv_q && !keep) begin
							st_q[rh_q] <= SS_IDLE;
							run_q <= rh_q;
							runv_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign run_valid = runv_q;
	assign run_slot = runv_q ? 4'(run_q) : 4'd0;

	`include "edf_task_scheduler_core_assert.svh"
	`EDF_ASSERT_NEXT(a_rel_adv, clk, arst_n, cmd.release_w, octr_q == $past(octr_q) + 32'd1)
	`EDF_ASSERT_IMP(a_set_cancel, clk, arst_n, end_timer_set, end_timer_cancel)
	`EDF_ASSERT_IMP(a_run_alloc, clk, arst_n, runv_q, st_q[run_q] != SS_FREE)
endmodule
`default_nettype wire

### rtl/core/edf_task_scheduler_core.sv
// EDF scheduler top level: one event in, one result out per event.
// Each event is handled by a sequential slot scan, a release check and a finish
// step; each released waiting task adds one more scan pass before the finish.
// Only one event at a time: in_ready stays low until the result is taken.
// Reset: asynchronous active-low arst_n frees all slots, clears the order
// counter and the running task; slot data is undefined until written.
`default_nettype none
module edf_task_scheduler_core import edf_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] func,
	input wire logic [3:0] task_slot,
	input wire logic [63:0] now,
	input wire logic [31:0] period,
	input wire logic [63:0] first_release,
	input wire logic [31:0] exec_budget,
	output logic out_valid,
	input wire logic out_ready,
	output logic [3:0] run_slot,
	output logic run_valid,
	output logic [3:0] alloc_slot,
	output logic [1:0] status,
	output logic end_timer_set,
	output logic end_timer_cancel,
	output logic [63:0] end_time,
	output logic release_valid,
	output logic [63:0] release_time,
	output logic resched_request
);
	cmd_t cmd;
	sts_t sts;
	logic is_sched;

	edf_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.is_sched, .sts, .cmd
	);

	edf_dp #(.SLOTS(SLOTS)) u_dp (
		.clk, .arst_n, .cmd, .sts, .is_sched,
		.in_func(func), .in_slot(task_slot), .in_now(now), .in_period(period),
		.in_first(first_release), .in_budget(exec_budget),
		.run_slot, .run_valid, .alloc_slot, .status, .end_timer_set,
		.end_timer_cancel, .end_time, .release_valid, .release_time, .resched_request
	);
endmodule
`default_nettype wire

### tb/sv/tb_edf_task_scheduler_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the EDF task scheduler core: directed events, then random events.
// Depends on edf_pkg, edf_if and edf_task_scheduler_core.
`default_nettype none
module tb_edf_task_scheduler_core;
	import edf_pkg::*;

	localparam int NSLOT = 16;
	localparam int N_RANDOM = 1230;
	localparam int QUIET_TAIL = 200;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [2:0] func;
		logic [3:0] task_slot;
		logic [63:0] now;
		logic [31:0] period;
		logic [63:0] first_release;
		logic [31:0] exec_budget;
	} sched_event_t;

	typedef struct packed {
		logic [3:0] run_slot;
		logic run_valid;
		logic [3:0] alloc_slot;
		logic [1:0] status;
		logic end_timer_set;
		logic end_timer_cancel;
		logic [63:0] end_time;
		logic release_valid;
		logic [63:0] release_time;
		logic resched_request;
	} sched_result_t;

	typedef struct {
		sched_event_t ev;
		bit fixed;
		sched_result_t res;
	} event_row_t;

	logic clk;
	logic arst_n;
	edf_if #(.T(sched_event_t)) ev_ch (clk);
	edf_if #(.T(sched_result_t)) res_ch (clk);

	edf_task_scheduler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(ev_ch.valid),
		.in_ready(ev_ch.ready),
		.func(ev_ch.data.func),
		.task_slot(ev_ch.data.task_slot),
		.now(ev_ch.data.now),
		.period(ev_ch.data.period),
		.first_release(ev_ch.data.first_release),
		.exec_budget(ev_ch.data.exec_budget),
		.out_valid(res_ch.valid),
		.out_ready(res_ch.ready),
		.run_slot(res_ch.data.run_slot),
		.run_valid(res_ch.data.run_valid),
		.alloc_slot(res_ch.data.alloc_slot),
		.status(res_ch.data.status),
		.end_timer_set(res_ch.data.end_timer_set),
		.end_timer_cancel(res_ch.data.end_timer_cancel),
		.end_time(res_ch.data.end_time),
		.release_valid(res_ch.data.release_valid),
		.release_time(res_ch.data.release_time),
		.resched_request(res_ch.data.resched_request)
	);

	// scheduler shadow state
	logic [1:0] slot_state [NSLOT];
	logic [63:0] slot_deadline [NSLOT];
	logic [31:0] slot_left [NSLOT];
	logic [63:0] slot_began [NSLOT];
	logic [31:0] slot_period [NSLOT];
	logic [31:0] slot_budget [NSLOT];
	logic [31:0] slot_stamp [NSLOT];
	logic [31:0] stamp_ctr;
	logic [3:0] cur_slot;
	logic cur_valid;

	sched_result_t expected_results [$];
	event_row_t rows [$];
	int errors;
	bit quiet;
	bit hold_sink;
	logic [63:0] clock_now;

	function automatic logic [63:0] add_clamp(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// earliest deadline, then oldest stamp, among slots in state st
	function automatic int queue_head(input logic [1:0] st);
		int best;
		best = -1;
		for (int i = 0; i < NSLOT; i++) begin
			if (slot_state[i] != st)
				continue;
			if (best < 0)
				best = i;
			else if (slot_deadline[i] < slot_deadline[best] ||
				(slot_deadline[i] == slot_deadline[best] &&
				 (stamp_ctr - slot_stamp[i]) > (stamp_ctr - slot_stamp[best])))
				best = i;
		end
		return best;
	endfunction

	function automatic void enqueue_slot(input int s, input logic [1:0] st);
		slot_state[s] = st;
		slot_stamp[s] = stamp_ctr;
		stamp_ctr = stamp_ctr + 1;
	endfunction

	function automatic sched_result_t schedule_step(input sched_event_t e);
		sched_result_t r;
		int f;
		int w;
		int h;
		int s;
		bit keep;
		logic [63:0] used;
		logic [31:0] left;
		r = '0;
		s = e.task_slot;
		case (e.func)
			FN_ALLOC: begin
				f = -1;
				for (int i = 0; i < NSLOT; i++)
					if (f < 0 && slot_state[i] == SS_FREE)
						f = i;
				if (f < 0) begin
					r.status = ST_NOFREE;
				end else begin
					slot_state[f] = SS_IDLE;
					slot_period[f] = e.period;
					slot_budget[f] = e.exec_budget;
					slot_left[f] = e.exec_budget;
					slot_deadline[f] = (e.period != 0) ?
						add_clamp(e.first_release, {32'd0, e.period}) : '1;
					r.alloc_slot = f[3:0];
				end
			end
			FN_ENQ: begin
				if (slot_state[s] == SS_IDLE)
					enqueue_slot(s, SS_READY);
			end
			FN_BLOCK: begin
				if (cur_valid && cur_slot == e.task_slot) begin
					used = e.now - slot_began[s];
					left = (used >= {32'd0, slot_left[s]}) ? 32'd0 : slot_left[s] - used[31:0];
					slot_left[s] = left;
					enqueue_slot(s, (left == 0) ? SS_WAIT : SS_READY);
					cur_valid = 1'b0;
					cur_slot = '0;
					r.end_timer_cancel = 1'b1;
					r.resched_request = 1'b1;
				end else begin
					r.status = ST_NOTRUN;
				end
			end
			FN_UNBLOCK: begin
				if (slot_state[s] == SS_IDLE && !(cur_valid && cur_slot == e.task_slot)) begin
					enqueue_slot(s, (slot_left[s] == 0) ? SS_WAIT : SS_READY);
					r.resched_request = 1'b1;
				end
			end
			FN_SCHED: begin
				// release every due waiting task, in queue order
				for (int i = 0; i < NSLOT; i++) begin
					w = queue_head(SS_WAIT);
					if (w < 0 || slot_deadline[w] > e.now)
						break;
					slot_deadline[w] = add_clamp(slot_deadline[w], {32'd0, slot_period[w]});
					slot_left[w] = slot_budget[w];
					enqueue_slot(w, SS_READY);
				end
				w = queue_head(SS_WAIT);
				if (w >= 0) begin
					r.release_valid = 1'b1;
					r.release_time = slot_deadline[w];
				end
				h = queue_head(SS_READY);
				if (h >= 0) begin
					keep = 1'b0;
					if (cur_valid) begin
						used = e.now - slot_began[cur_slot];
						keep = {32'd0, slot_left[cur_slot]} > used &&
							slot_deadline[cur_slot] < slot_deadline[h];
					end
					if (!keep) begin
						slot_began[h] = e.now;
						slot_state[h] = SS_IDLE;
						cur_slot = h[3:0];
						cur_valid = 1'b1;
						r.end_timer_cancel = 1'b1;
						r.end_timer_set = 1'b1;
						r.end_time = add_clamp(e.now, {32'd0, slot_left[h]});
					end
				end
			end
			FN_YIELD: begin
				r.end_timer_cancel = 1'b1;
				r.resched_request = 1'b1;
			end
			default: ;
		endcase
		r.run_slot = cur_valid ? cur_slot : 4'd0;
		r.run_valid = cur_valid;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		errors++;
		$display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
	endtask

	task automatic add_row(input logic [2:0] fn, input int s, input logic [63:0] t,
		input logic [31:0] per, input logic [63:0] first, input logic [31:0] bud,
		input bit fixed, input sched_result_t res);
		event_row_t row;
		row.ev = '{func: fn, task_slot: s[3:0], now: t, period: per, first_release: first,
			exec_budget: bud};
		row.fixed = fixed;
		row.res = res;
		rows.push_back(row);
	endtask

	function automatic sched_event_t random_event();
		sched_event_t e;
		int pick;
		e.now = '0;
		clock_now = clock_now + 64'($urandom_range(0, 20));
		e.now = ($urandom_range(0, 39) == 0) ? {$urandom, $urandom} : clock_now;
		e.task_slot = 4'($urandom_range(0, NSLOT - 1));
		pick = $urandom_range(0, 99);
		if (pick < 10)
			e.func = FN_ALLOC;
		else if (pick < 20)
			e.func = FN_ENQ;
		else if (pick < 40) begin
			e.func = FN_BLOCK;
			// mostly block the task that actually runs
			if (cur_valid && $urandom_range(0, 3) != 0)
				e.task_slot = cur_slot;
		end else if (pick < 55)
			e.func = FN_UNBLOCK;
		else if (pick < 87)
			e.func = FN_SCHED;
		else if (pick < 96)
			e.func = FN_YIELD;
		else
			e.func = 3'($urandom_range(6, 7));
		pick = $urandom_range(0, 15);
		e.period = (pick < 2) ? 32'd0 : (pick == 2) ? $urandom : $urandom_range(1, 40);
		pick = $urandom_range(0, 15);
		e.exec_budget = (pick < 2) ? 32'd0 : (pick == 2) ? $urandom : $urandom_range(1, 20);
		e.first_release = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
			clock_now + 64'($urandom_range(0, 30));
		return e;
	endfunction

	// send one event: optional gap, then hold valid until the transfer
	task automatic send_event(input sched_event_t e, input bit fixed, input sched_result_t res);
		sched_result_t guess;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			ev_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		ev_ch.valid <= 1'b1;
		ev_ch.data <= e;
		do @(posedge clk); while (!ev_ch.ready);
		guess = schedule_step(e);
		expected_results.push_back(fixed ? res : guess);
	endtask

	task automatic drain();
		ev_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// sink side: random back-pressure plus one long hold-off
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				res_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_sink = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", {60'd0, res_ch.data.run_slot}, 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (res_ch.data.run_slot !== want.run_slot)
					report_mismatch("run_slot", res_ch.data.run_slot, want.run_slot);
				if (res_ch.data.run_valid !== want.run_valid)
					report_mismatch("run_valid", res_ch.data.run_valid, want.run_valid);
				if (res_ch.data.alloc_slot !== want.alloc_slot)
					report_mismatch("alloc_slot", res_ch.data.alloc_slot, want.alloc_slot);
				if (res_ch.data.status !== want.status)
					report_mismatch("status", res_ch.data.status, want.status);
				if (res_ch.data.end_timer_set !== want.end_timer_set)
					report_mismatch("end_timer_set", res_ch.data.end_timer_set,
						want.end_timer_set);
				if (res_ch.data.end_timer_cancel !== want.end_timer_cancel)
					report_mismatch("end_timer_cancel", res_ch.data.end_timer_cancel,
						want.end_timer_cancel);
				if (res_ch.data.end_time !== want.end_time)
					report_mismatch("end_time", res_ch.data.end_time, want.end_time);
				if (res_ch.data.release_valid !== want.release_valid)
					report_mismatch("release_valid", res_ch.data.release_valid,
						want.release_valid);
				if (res_ch.data.release_time !== want.release_time)
					report_mismatch("release_time", res_ch.data.release_time,
						want.release_time);
				if (res_ch.data.resched_request !== want.resched_request)
					report_mismatch("resched_request", res_ch.data.resched_request,
						want.resched_request);
			end
		end
	end

	initial begin
		longint cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout with %0d results outstanding", expected_results.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		sched_result_t z;
		sched_result_t r;
		errors = 0;
		quiet = 1'b0;
		hold_sink = 1'b0;
		clock_now = 64'd100;
		for (int i = 0; i < NSLOT; i++) begin
			slot_state[i] = SS_FREE;
			slot_deadline[i] = '0;
			slot_left[i] = '0;
			slot_began[i] = '0;
			slot_period[i] = '0;
			slot_budget[i] = '0;
			slot_stamp[i] = '0;
		end
		stamp_ctr = '0;
		cur_slot = '0;
		cur_valid = 1'b0;
		arst_n = 1'b0;
		ev_ch.valid = 1'b0;
		ev_ch.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		z = '0;
		// nothing allocated yet: schedule is empty, block is refused
		add_row(FN_SCHED, 0, '1, '0, '0, '0, 1, z);
		r = z; r.status = ST_NOTRUN;
		add_row(FN_BLOCK, 15, '0, '0, '0, '0, 1, r);
		// aperiodic task with the largest budget
		add_row(FN_ALLOC, 7, 64'd0, 32'd0, '1, '1, 1, z);
		r = z; r.alloc_slot = 4'd1;
		// deadline saturates
		add_row(FN_ALLOC, 0, 64'd0, '1, '1, 32'd5, 1, r);
		r = z; r.alloc_slot = 4'd2;
		// zero budget: unblock goes straight to waiting
		add_row(FN_ALLOC, 0, 64'd0, 32'd10, 64'd0, 32'd0, 1, r);
		add_row(FN_ALLOC, 0, 64'd0, 32'd10, 64'd0, 32'd3, 0, z);
		add_row(FN_ENQ, 1, 64'd0, '0, '0, '0, 0, z);
		add_row(FN_ENQ, 1, 64'd0, '0, '0, '0, 0, z);
		add_row(FN_UNBLOCK, 2, 64'd0, '0, '0, '0, 0, z);
		add_row(FN_UNBLOCK, 3, 64'd0, '0, '0, '0, 0, z);
		add_row(FN_SCHED, 0, 64'd1, '0, '0, '0, 0, z);
		add_row(FN_YIELD, 0, 64'd2, '0, '0, '0, 0, z);
		add_row(FN_SCHED, 0, 64'd3, '0, '0, '0, 0, z);
		add_row(FN_BLOCK, 3, 64'd9, '0, '0, '0, 0, z);
		add_row(3'd6, 5, '1, '1, '1, '1, 0, z);
		add_row(3'd7, 10, '1, '1, '1, '1, 0, z);
		// waiting task comes due at its deadline
		add_row(FN_SCHED, 0, 64'd10, '0, '0, '0, 0, z);
		add_row(FN_ENQ, 0, 64'd10, '0, '0, '0, 0, z);
		add_row(FN_SCHED, 0, 64'd11, '0, '0, '0, 0, z);
		add_row(FN_BLOCK, 0, 64'hffff_ffff_ffff_fff0, '0, '0, '0, 0, z);
		add_row(FN_SCHED, 0, '1, '0, '0, '0, 0, z);
		foreach (rows[k])
			send_event(rows[k].ev, rows[k].fixed, rows[k].res);
		drain();

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 300)
				hold_sink = 1'b1;
			if (n == 600)
				drain();
			if (n == N_RANDOM - QUIET_TAIL)
				quiet = 1'b1;
			send_event(random_event(), 0, z);
		end
		ev_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
